/* design/rme_pkg.sv */
// shared constants and command/status types for the modular exponentiation block
`default_nettype none

package rme_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 2'd1;

    localparam logic [31:0] MODULUS_RESET  = 32'd6554179;
    localparam logic [31:0] EXPONENT_RESET = 32'd55621;

    // which modular product the shared multiplier is working on
    typedef enum logic [1:0] {
        OP_RED = 2'd0,
        OP_MUL = 2'd1,
        OP_SQR = 2'd2
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    start;
        mul_op_t op;
        logic    step;
        logic    last;
        logic    next_bit;
        logic    emit;
    } rme_cmd_t;

    typedef struct packed {
        logic ebit;
        logic ezero;
    } rme_status_t;

endpackage

`default_nettype wire

/* design/rme_if.sv */
// valid/ready stream interfaces for cipher input and plain output
`default_nettype none

interface rme_cipher_if #(
    parameter int W = rme_pkg::WORD_BITS_DEFAULT
);
    logic         valid;
    logic         ready;
    logic [W-1:0] cipher_word;

    modport source (output valid, output cipher_word, input ready);
    modport sink   (input valid, input cipher_word, output ready);
endinterface

interface rme_plain_if #(
    parameter int W = rme_pkg::WORD_BITS_DEFAULT
);
    logic         valid;
    logic         ready;
    logic [W-1:0] plain_word;

    modport source (output valid, output plain_word, input ready);
    modport sink   (input valid, input plain_word, output ready);
endinterface

`default_nettype wire

/* design/rme_datapath.sv */
// bit-serial modular multiplier, base/accumulator registers and result register
`default_nettype none

module rme_datapath #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire rme_pkg::rme_cmd_t    cmd,
    input  wire logic [WORD_BITS-1:0] cipher_word,
    input  wire logic [WORD_BITS-1:0] modulus,
    input  wire logic [WORD_BITS-1:0] exponent,
    output rme_pkg::rme_status_t      status,
    output logic [WORD_BITS-1:0]      plain_word
);

    localparam int XW = WORD_BITS + 1;

    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] r_reg;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [WORD_BITS-1:0] plain_reg;
    rme_pkg::mul_op_t     op_reg;

    logic [XW-1:0]        m_ext;
    logic [XW-1:0]        dbl;
    logic [XW-1:0]        dbl_red;
    logic [XW-1:0]        addend;
    logic [XW-1:0]        sum;
    logic [XW-1:0]        sum_red;
    logic [WORD_BITS-1:0] r_next;

    // a zero modulus acts as 2^WORD_BITS
    assign m_ext = {(modulus == '0), modulus};

    // one multiplier bit per step, msb first: r = 2r + a_i*b mod n
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        addend  = a_reg[WORD_BITS-1] ? {1'b0, b_reg} : '0;
        sum     = dbl_red + addend;
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
        r_next  = sum_red[WORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // first product is cipher * 1, which reduces the cipher word
            a_reg    <= cipher_word;
            b_reg    <= WORD_BITS'(1);
            r_reg    <= '0;
            acc_reg  <= WORD_BITS'(1);
            e_reg    <= exponent;
            op_reg   <= rme_pkg::OP_RED;
        end
        else if (cmd.start)
        begin
            a_reg  <= (cmd.op == rme_pkg::OP_MUL) ? acc_reg : base_reg;
            b_reg  <= base_reg;
            r_reg  <= '0;
            op_reg <= cmd.op;
        end
        else if (cmd.step)
        begin
            r_reg <= r_next;
            a_reg <= {a_reg[WORD_BITS-2:0], 1'b0};
            if (cmd.last)
            begin
                case (op_reg)
                    rme_pkg::OP_MUL: acc_reg  <= r_next;
                    default:         base_reg <= r_next;
                endcase
            end
        end

        if (cmd.next_bit)
        begin
            e_reg <= {1'b0, e_reg[WORD_BITS-1:1]};
        end

        if (cmd.emit)
        begin
            plain_reg <= acc_reg;
        end
    end

    assign status.ebit  = e_reg[0];
    assign status.ezero = (exponent == '0);
    assign plain_word   = plain_reg;

endmodule

`default_nettype wire

/* design/rme_controller.sv */
// sequencer for square-and-multiply over the exponent bits and the handshakes
`default_nettype none

module rme_controller #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rme_pkg::rme_status_t status,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rme_pkg::rme_cmd_t        cmd
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_SEL  = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQS  = 6'b010000,
        S_SQR  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] bit_reg, bit_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.op         = rme_pkg::OP_RED;
        state_next     = state_reg;
        done_next      = done_reg;
        step_next      = step_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        if (done_reg)
        begin
            // result waits here until the output register is free
            if (!out_valid_reg || out_ready)
            begin
                cmd.emit       = 1'b1;
                out_valid_next = 1'b1;
                done_next      = 1'b0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load  = 1'b1;
                        step_next = '0;
                        bit_next  = '0;
                        if (status.ezero)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RED;
                        end
                    end
                end
                S_RED:
                begin
                    cmd.step = 1'b1;
                    if (step_reg == CNT_LAST)
                    begin
                        cmd.last   = 1'b1;
                        state_next = S_SEL;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                S_SEL:
                begin
                    cmd.start = 1'b1;
                    step_next = '0;
                    if (status.ebit)
                    begin
                        cmd.op     = rme_pkg::OP_MUL;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cmd.op     = rme_pkg::OP_SQR;
                        state_next = S_SQR;
                    end
                end
                S_MUL:
                begin
                    cmd.step = 1'b1;
                    if (step_reg == CNT_LAST)
                    begin
                        cmd.last   = 1'b1;
                        state_next = S_SQS;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                S_SQS:
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = rme_pkg::OP_SQR;
                    step_next  = '0;
                    state_next = S_SQR;
                end
                S_SQR:
                begin
                    cmd.step = 1'b1;
                    if (step_reg == CNT_LAST)
                    begin
                        cmd.last     = 1'b1;
                        cmd.next_bit = 1'b1;
                        if (bit_reg == CNT_LAST)
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 1'b1;
                            state_next = S_SEL;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            step_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            step_reg      <= step_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* design/rsa_modular_exponentiation.sv */
// top level: configuration registers, controller and bit-serial datapath
//
//  channel   dir  beat fields          handshake
//  in        in   cipher_word          in.valid / in.ready
//  out       out  plain_word           out.valid / out.ready
//  cfg       in   cfg_index, cfg_data  cfg_we (no ready)
//
// one item reduces the cipher word, then for each exponent bit, lsb first, multiplies
// when the bit is set and squares the base; a zero exponent skips the multiplier.
// the shared modular multiplier retires one multiplier bit per cycle.
// reset loads the default modulus and exponent and clears the sequencer.
// one item is in flight at a time; a finished result waits in the output
// register, and a new item is taken while it waits.
`default_nettype none

module rsa_modular_exponentiation #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rme_cipher_if.sink                           in,
    rme_plain_if.source                          out,
    input  wire logic                            cfg_we,
    input  wire logic [rme_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]            cfg_data
);

    localparam logic [WORD_BITS-1:0] MOD_RST = rme_pkg::MODULUS_RESET[WORD_BITS-1:0];
    localparam logic [WORD_BITS-1:0] EXP_RST = rme_pkg::EXPONENT_RESET[WORD_BITS-1:0];

    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] exponent_reg;
    rme_pkg::rme_cmd_t    cmd;
    rme_pkg::rme_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_RST;
            exponent_reg <= EXP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rme_pkg::CFG_MODULUS:  modulus_reg  <= cfg_data;
                rme_pkg::CFG_EXPONENT: exponent_reg <= cfg_data;
                default:
                begin
                    modulus_reg <= modulus_reg;
                end
            endcase
        end
    end

    rme_controller #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd)
    );

    rme_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .cipher_word (in.cipher_word),
        .modulus     (modulus_reg),
        .exponent    (exponent_reg),
        .status      (status),
        .plain_word  (out.plain_word)
    );

endmodule

`default_nettype wire

/* bench/rsa_modular_exponentiation_tb.sv */
// self-checking bench for the modular exponentiation block with random flow control
`default_nettype none

module rsa_modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = rme_pkg::WORD_BITS_DEFAULT;
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int DRAIN_CYCLES = 2200;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 22;

    // indexes with no register behind them
    localparam logic [rme_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rme_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [rme_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [W-1:0] cfg_data;

    rme_cipher_if #(.W(W)) cin ();
    rme_plain_if #(.W(W)) cout ();

    rsa_modular_exponentiation #(.WORD_BITS(W)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (cin),
        .out       (cout),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bench copy of the registers
    logic [W-1:0] modulus_q;
    logic [W-1:0] exponent_q;

    logic [W-1:0] cipher_q[$];
    logic [W-1:0] plain_q[$];
    logic [W-1:0] plain_exp;

    int  queued_count = 0;
    int  done_count = 0;
    int  errors = 0;
    int  cycle_count = 0;
    bit  idling = 1'b1;
    logic beat_taken = 1'b0;
    int  gap_left = 0;
    int  burst_left = 1;
    int  stall_left = 0;
    int  run_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [W-1:0] mod_pow(input logic [W-1:0] c, input logic [W-1:0] d,
                                             input logic [W-1:0] n);
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] n64;
        int k;
        n64 = {32'd0, n};
        acc = 64'd1;
        base = {32'd0, c} % n64;
        if (d == '0)
            return W'(1);
        for (k = 0; k < W; k++)
        begin
            if (d[k])
                acc = (acc * base) % n64;
            base = (base * base) % n64;
        end
        return acc[W-1:0];
    endfunction

    function automatic int pick_idle(input int pct_none, input int short_max,
                                     input int long_lo, input int long_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_none)
            return 0;
        if (r < 92)
            return $urandom_range(1, short_max);
        return $urandom_range(long_lo, long_hi);
    endfunction

    // sender: bursts of beats separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            cin.valid <= 1'b0;
        else if (!cin.valid || beat_taken)
        begin
            if (idling && gap_left > 0)
            begin
                cin.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cipher_q.size() > 0)
            begin
                cin.valid <= 1'b1;
                cin.cipher_word <= cipher_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= pick_idle(50, 20, 100, 2500);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                cin.valid <= 1'b0;
        end
    end

    // receiver: runs of ready followed by stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            cout.ready <= 1'b0;
        else if (!idling)
            cout.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            cout.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (run_left > 0)
        begin
            cout.ready <= 1'b1;
            run_left <= run_left - 1;
        end
        else
        begin
            cout.ready <= 1'b1;
            run_left <= $urandom_range(1, 12);
            stall_left <= pick_idle(40, 15, 200, 2500);
        end
    end

    // monitor: check each output beat, then predict for each input beat
    always @(posedge clk)
    begin
        beat_taken <= cin.valid && cin.ready;
        if (rst_n)
        begin
            if (cout.valid && cout.ready)
            begin
                done_count++;
                if (plain_q.size() == 0)
                begin
                    $display("%0t: unexpected plain_word beat, expected none, got %08h",
                             $time, cout.plain_word);
                    errors++;
                end
                else
                begin
                    plain_exp = plain_q.pop_front();
                    if (cout.plain_word !== plain_exp)
                    begin
                        $display("%0t: plain_word mismatch, expected %08h, got %08h",
                                 $time, plain_exp, cout.plain_word);
                        errors++;
                    end
                end
            end
            if (cin.valid && cin.ready)
                plain_q.push_back(mod_pow(cin.cipher_word, exponent_q, modulus_q));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, queued_count - done_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (done_count < queued_count)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [rme_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        if (idx == rme_pkg::CFG_MODULUS)
            modulus_q = data;
        else if (idx == rme_pkg::CFG_EXPONENT)
            exponent_q = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send(input logic [W-1:0] word);
        cipher_q.push_back(word);
        queued_count++;
    endtask

    initial
    begin
        int p;
        int i;
        logic [W-1:0] n;
        logic [W-1:0] d;
        logic [W-1:0] c;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rme_pkg::CFG_MODULUS;
        cfg_data = '0;
        cin.valid = 1'b0;
        cin.cipher_word = '0;
        cout.ready = 1'b0;
        modulus_q = rme_pkg::MODULUS_RESET;
        exponent_q = rme_pkg::EXPONENT_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of both registers
        @(posedge clk);
        send(32'd0);
        send(32'd1);
        send(32'd2);
        send(rme_pkg::MODULUS_RESET - 1);
        send(rme_pkg::MODULUS_RESET);
        send(32'hFFFF_FFFF);
        send(32'h8000_0000);
        send(32'h5555_5555);
        send(32'hAAAA_AAAA);

        // zero exponent gives one even for modulus one
        wait_idle();
        write_reg(rme_pkg::CFG_MODULUS, 32'd1);
        write_reg(rme_pkg::CFG_EXPONENT, 32'd0);
        @(posedge clk);
        send(32'd0);
        send(32'd5);
        send(32'hFFFF_FFFF);

        wait_idle();
        write_reg(rme_pkg::CFG_EXPONENT, 32'hFFFF_FFFF);
        @(posedge clk);
        send(32'd7);
        send(32'hFFFF_FFFF);

        // widest modulus and exponent, all bits set
        wait_idle();
        write_reg(rme_pkg::CFG_MODULUS, 32'hFFFF_FFFF);
        @(posedge clk);
        send(32'hFFFF_FFFF);
        send(32'hFFFF_FFFE);
        send(32'd2);
        send(32'd3);

        // writes to unused indexes leave both registers alone
        wait_idle();
        write_reg(rme_pkg::CFG_MODULUS, 32'hFFFF_FFFB);
        write_reg(rme_pkg::CFG_EXPONENT, 32'd1);
        write_reg(CFG_SPARE_A, 32'd0);
        write_reg(CFG_SPARE_B, 32'd1);
        @(posedge clk);
        send(32'hFFFF_FFFA);
        send(32'hFFFF_FFFC);
        send(32'h1234_5678);
        send(32'd0);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0: n = $urandom_range(1, 255);
                1: n = $urandom | 32'h8000_0000;
                default:
                begin
                    n = $urandom;
                    if (n == '0)
                        n = 32'd1;
                end
            endcase
            case ($urandom_range(0, 9))
                0: d = '0;
                1: d = 32'd1;
                2: d = 32'hFFFF_FFFF;
                3: d = $urandom_range(2, 255);
                default: d = $urandom;
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(rme_pkg::CFG_MODULUS, n);
                write_reg(rme_pkg::CFG_EXPONENT, d);
            end
            else
            begin
                write_reg(rme_pkg::CFG_EXPONENT, d);
                write_reg(rme_pkg::CFG_MODULUS, n);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
            @(posedge clk);
            // every fourth phase runs with no gaps and no stalls
            idling = (p % 4 != 3);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 7))
                    0: c = $urandom_range(0, 3);
                    1: c = modulus_q - 1;
                    2: c = 32'hFFFF_FFFF;
                    3: c = modulus_q;
                    default: c = $urandom;
                endcase
                send(c);
            end
        end

        wait_idle();
        idling = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && plain_q.size() == 0)
            $display("All tests passed");
        else
        begin
            if (plain_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, plain_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* rsa_modular_exponentiation.f */
design/rme_pkg.sv
design/rme_if.sv
design/rme_datapath.sv
design/rme_controller.sv
design/rsa_modular_exponentiation.sv
bench/rsa_modular_exponentiation_tb.sv
